/* src/cad_pkg.sv */
// Shared types and constants of the cube apodization core.
// Depends on nothing; every other file takes names from here by scope.
package cad_pkg;

   localparam int MAX_COLUMNS_DEF = 1024;
   localparam int MAX_ROWS_DEF    = 1024;
   localparam int MAX_PLANES_DEF  = 4096;

   localparam int COLS_W      = 11;
   localparam int ROWS_W      = 11;
   localparam int PLANES_W    = 13;
   localparam int EDGE_W      = 16;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;
   localparam int SAMPLE_W    = 32;
   localparam int WEIGHT_W    = 31;
   localparam int QUEUE_DEPTH = 2;
   localparam int DIV_N_W     = 64;
   localparam int DIV_D_W     = 32;

   localparam logic [15:0] ONE15 = 16'h8000;

   localparam logic [COLS_W-1:0]   COLS_RST   = 11'd64;
   localparam logic [ROWS_W-1:0]   ROWS_RST   = 11'd64;
   localparam logic [PLANES_W-1:0] PLANES_RST = 13'd64;
   localparam logic [EDGE_W-1:0]   INNER_RST  = 16'd15360;
   localparam logic [EDGE_W-1:0]   OUTER_RST  = 16'd16384;
   localparam logic [EDGE_W-1:0]   TIME_RST   = 16'd31744;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_COLUMNS   = 3'd0,
      CSR_ROWS      = 3'd1,
      CSR_PLANES    = 3'd2,
      CSR_INNER     = 3'd3,
      CSR_OUTER     = 3'd4,
      CSR_TIME_EDGE = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic [COLS_W-1:0]   columns;
      logic [ROWS_W-1:0]   rows;
      logic [PLANES_W-1:0] planes;
      logic [EDGE_W-1:0]   inner_edge;
      logic [EDGE_W-1:0]   outer_edge;
      logic [EDGE_W-1:0]   time_edge;
   } cfg_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample;
      logic [WEIGHT_W-1:0]        weight;
      logic                       done;
   } entry_type;

endpackage

/* src/cad_div.sv */
// Iterative restoring divider, one quotient bit per cycle.
// Depends on cad_pkg for operand widths.
module cad_div (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [cad_pkg::DIV_N_W-1:0]  num,
   input  logic [cad_pkg::DIV_D_W-1:0]  den,
   output logic                         done,
   output logic [cad_pkg::DIV_N_W-1:0]  quo
);
   localparam int NW = cad_pkg::DIV_N_W;
   localparam int DW = cad_pkg::DIV_D_W;
   localparam int CW = $clog2(NW);

   logic          busy_ff;
   logic          done_ff;
   logic [CW-1:0] cnt_ff;
   logic [DW:0]   rem_ff;
   logic [NW-1:0] quo_ff;
   logic [DW-1:0] den_ff;
   logic [DW:0]   rem_sh;
   logic          fit;

   assign rem_sh = {rem_ff[DW-1:0], quo_ff[NW-1]};
   assign fit    = rem_sh >= {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CW'(NW - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         quo_ff <= num;
         den_ff <= den;
      end else if (busy_ff) begin
         rem_ff <= fit ? (rem_sh - {1'b0, den_ff}) : rem_sh;
         quo_ff <= {quo_ff[NW-2:0], fit};
      end
   end

   assign done = done_ff;
   assign quo  = quo_ff;
endmodule

/* src/cad_front.sv */
// Front end: position counters, item intake and weight sequencer.
// Depends on cad_pkg and cad_div; one shared multiplier, one divider.
module cad_front #(
   parameter int MAX_COLUMNS = cad_pkg::MAX_COLUMNS_DEF,
   parameter int MAX_ROWS    = cad_pkg::MAX_ROWS_DEF,
   parameter int MAX_PLANES  = cad_pkg::MAX_PLANES_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  cad_pkg::cfg_type                   cfg,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic signed [cad_pkg::SAMPLE_W-1:0] req_sample,
   input  logic                               req_sample_invalid,
   output logic                               push_valid,
   input  logic                               push_ready,
   output cad_pkg::entry_type                 push_entry
);
   localparam int CW  = $clog2(MAX_COLUMNS);
   localparam int RW  = $clog2(MAX_ROWS);
   localparam int PW  = $clog2(MAX_PLANES);
   localparam int CDW = $clog2(MAX_COLUMNS + 1);
   localparam int RDW = $clog2(MAX_ROWS + 1);
   localparam int PDW = $clog2(MAX_PLANES + 1);

   typedef enum logic [17:0] {
      F_IDLE    = 18'h00001,
      F_T_ED    = 18'h00002,
      F_T_DEN   = 18'h00004,
      F_T_CMP   = 18'h00008,
      F_T_DIV   = 18'h00010,
      F_TAP_SQ  = 18'h00020,
      F_TAP_A   = 18'h00040,
      F_TAP_W   = 18'h00080,
      F_R_START = 18'h00100,
      F_R_AN    = 18'h00200,
      F_R_DEN   = 18'h00400,
      F_R_DIV   = 18'h00800,
      F_R_WAIT  = 18'h01000,
      F_SQRT    = 18'h02000,
      F_R_EDGE  = 18'h04000,
      F_R_DIV2  = 18'h08000,
      F_W_MUL   = 18'h10000,
      F_PUSH    = 18'h20000
   } state_type;

   state_type state_ff, state_in;

   logic [CDW-1:0] cols;
   logic [RDW-1:0] rows;
   logic [PDW-1:0] planes;

   logic [CW-1:0] col_ff, pos_c_ff;
   logic [RW-1:0] row_ff, pos_r_ff;
   logic [PW-1:0] plane_ff, pos_p_ff;
   logic          last_col, last_row, last_plane;

   logic signed [cad_pkg::SAMPLE_W-1:0] sample_ff;
   logic          done_ff;
   logic [15:0]   wt_ff, wr_ff, tap_x_ff;
   logic          tap_rad_ff;
   logic          axis_ff;
   logic          skip_ff;
   logic [63:0]   prod_ff, ed_ff, ansq_ff, rr_ff;
   logic [63:0]   x_ff, res_ff, bit_ff;
   logic [31:0]   mul_a, mul_b;

   logic          div_start, div_done;
   logic [63:0]   div_num, div_quo;
   logic [31:0]   div_den;

   logic          accept, time_off;
   logic [31:0]   d, pc, n, n2, q;
   logic [31:0]   axis_sz, axis_pos, h, den_ax, an;
   logic          e_ax;
   logic signed [31:0] num_ax;
   logic [63:0]   q15, sq_try, rr_next, rad;
   logic [15:0]   ei, eo, te, tap_a;
   logic          time_gt;

   always_comb begin
      if (cfg.columns == '0) cols = CDW'(1);
      else if (32'(cfg.columns) > 32'(MAX_COLUMNS)) cols = CDW'(MAX_COLUMNS);
      else cols = CDW'(cfg.columns);
      if (cfg.rows == '0) rows = RDW'(1);
      else if (32'(cfg.rows) > 32'(MAX_ROWS)) rows = RDW'(MAX_ROWS);
      else rows = RDW'(cfg.rows);
      if (cfg.planes == '0) planes = PDW'(1);
      else if (32'(cfg.planes) > 32'(MAX_PLANES)) planes = PDW'(MAX_PLANES);
      else planes = PDW'(cfg.planes);
   end

   assign ei = cfg.inner_edge;
   assign eo = cfg.outer_edge;
   assign te = cfg.time_edge;

   assign req_ready  = (state_ff == F_IDLE);
   assign accept     = req_valid && req_ready;
   assign last_col   = 32'(col_ff) + 32'd1 >= 32'(cols);
   assign last_row   = 32'(row_ff) + 32'd1 >= 32'(rows);
   assign last_plane = 32'(plane_ff) + 32'd1 >= 32'(planes);
   assign time_off   = (32'(planes) < 32'd2) || (te >= cad_pkg::ONE15);

   always_comb begin
      d  = 32'(planes) - 32'd1;
      pc = (32'(pos_p_ff) > d) ? d : 32'(pos_p_ff);
      n  = pc << 1;
      n2 = (n > d) ? ((d << 1) - n) : n;
      q  = d - n2;
      q15 = 64'(q) << 15;
      time_gt = q15 > ed_ff;
   end

   always_comb begin
      axis_sz  = axis_ff ? 32'(rows) : 32'(cols);
      axis_pos = axis_ff ? 32'(pos_r_ff) : 32'(pos_c_ff);
      h        = axis_sz >> 1;
      e_ax     = ~axis_sz[0];
      num_ax   = $signed((axis_pos << 1) + 32'(e_ax)) - $signed(h << 1);
      an       = num_ax[31] ? 32'(-num_ax) : 32'(num_ax);
      den_ax   = (h << 1) + 32'(e_ax);
      rr_next  = rr_ff + (skip_ff ? 64'd0 : div_quo);
      sq_try   = res_ff + bit_ff;
      rad      = res_ff;
      tap_a    = cad_pkg::ONE15 - prod_ff[30:15];
   end

   always_comb begin
      mul_a     = '0;
      mul_b     = '0;
      div_start = 1'b0;
      div_num   = '0;
      div_den   = '0;
      state_in  = state_ff;
      unique case (state_ff)
         F_IDLE: begin
            if (accept) state_in = time_off ? F_R_START : F_T_ED;
         end
         F_T_ED: begin
            mul_a    = 32'(te);
            mul_b    = d;
            state_in = F_T_DEN;
         end
         F_T_DEN: begin
            mul_a    = 32'(cad_pkg::ONE15 - te);
            mul_b    = d;
            state_in = F_T_CMP;
         end
         F_T_CMP: begin
            div_start = time_gt;
            div_num   = (q15 - ed_ff) << 15;
            div_den   = prod_ff[31:0];
            state_in  = time_gt ? F_T_DIV : F_R_START;
         end
         F_T_DIV: begin
            if (div_done) state_in = F_TAP_SQ;
         end
         F_TAP_SQ: begin
            mul_a    = 32'(tap_x_ff);
            mul_b    = 32'(tap_x_ff);
            state_in = F_TAP_A;
         end
         F_TAP_A: begin
            mul_a    = 32'(tap_a);
            mul_b    = 32'(tap_a);
            state_in = F_TAP_W;
         end
         F_TAP_W: begin
            state_in = tap_rad_ff ? F_W_MUL : F_R_START;
         end
         F_R_START: begin
            state_in = (eo == '0) ? F_W_MUL : F_R_AN;
         end
         F_R_AN: begin
            mul_a    = an;
            mul_b    = an;
            state_in = F_R_DEN;
         end
         F_R_DEN: begin
            mul_a    = den_ax;
            mul_b    = den_ax;
            state_in = F_R_DIV;
         end
         F_R_DIV: begin
            div_start = (prod_ff != '0);
            div_num   = ansq_ff << 28;
            div_den   = prod_ff[31:0];
            state_in  = F_R_WAIT;
         end
         F_R_WAIT: begin
            if (skip_ff || div_done) state_in = axis_ff ? F_SQRT : F_R_AN;
         end
         F_SQRT: begin
            if (bit_ff == 64'd1) state_in = F_R_EDGE;
         end
         F_R_EDGE: begin
            if (ei >= eo || rad <= 64'(ei) || rad >= 64'(eo)) begin
               state_in = F_W_MUL;
            end else begin
               div_start = 1'b1;
               div_num   = (rad - 64'(ei)) << 15;
               div_den   = 32'(eo - ei);
               state_in  = F_R_DIV2;
            end
         end
         F_R_DIV2: begin
            if (div_done) state_in = F_TAP_SQ;
         end
         F_W_MUL: begin
            mul_a    = 32'(wt_ff);
            mul_b    = 32'(wr_ff);
            state_in = F_PUSH;
         end
         F_PUSH: begin
            mul_a    = 32'(wt_ff);
            mul_b    = 32'(wr_ff);
            if (push_ready) state_in = F_IDLE;
         end
         default: state_in = F_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
         col_ff   <= '0;
         row_ff   <= '0;
         plane_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (accept) begin
            if (!last_col) col_ff <= col_ff + 1'b1;
            else begin
               col_ff <= '0;
               if (!last_row) row_ff <= row_ff + 1'b1;
               else begin
                  row_ff <= '0;
                  if (!last_plane) plane_ff <= plane_ff + 1'b1;
                  else plane_ff <= '0;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= 64'(mul_a) * 64'(mul_b);
      unique case (state_ff)
         F_IDLE: begin
            pos_c_ff  <= col_ff;
            pos_r_ff  <= row_ff;
            pos_p_ff  <= plane_ff;
            sample_ff <= req_sample_invalid ? '0 : req_sample;
            done_ff   <= last_col && last_row && last_plane;
            wt_ff     <= cad_pkg::ONE15;
            wr_ff     <= cad_pkg::ONE15;
         end
         F_T_DEN: ed_ff <= prod_ff;
         F_T_DIV: begin
            tap_x_ff   <= (div_quo > 64'(cad_pkg::ONE15)) ? cad_pkg::ONE15 : div_quo[15:0];
            tap_rad_ff <= 1'b0;
         end
         F_TAP_W: begin
            if (tap_rad_ff) wr_ff <= prod_ff[30:15];
            else wt_ff <= prod_ff[30:15];
         end
         F_R_START: begin
            axis_ff <= 1'b0;
            rr_ff   <= '0;
         end
         F_R_DEN: ansq_ff <= prod_ff;
         F_R_DIV: skip_ff <= (prod_ff == '0);
         F_R_WAIT: begin
            if (skip_ff || div_done) begin
               rr_ff   <= rr_next;
               axis_ff <= 1'b1;
               x_ff    <= rr_next;
               res_ff  <= '0;
               bit_ff  <= 64'd1 << 62;
            end
         end
         F_SQRT: begin
            if (x_ff >= sq_try) begin
               x_ff   <= x_ff - sq_try;
               res_ff <= (res_ff >> 1) + bit_ff;
            end else begin
               res_ff <= res_ff >> 1;
            end
            bit_ff <= bit_ff >> 2;
         end
         F_R_EDGE: begin
            if (ei >= eo) wr_ff <= (rad < 64'(eo)) ? cad_pkg::ONE15 : 16'd0;
            else if (rad <= 64'(ei)) wr_ff <= cad_pkg::ONE15;
            else if (rad >= 64'(eo)) wr_ff <= 16'd0;
         end
         F_R_DIV2: begin
            tap_x_ff   <= div_quo[15:0];
            tap_rad_ff <= 1'b1;
         end
         default: begin
         end
      endcase
   end

   cad_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quo   (div_quo)
   );

   assign push_valid        = (state_ff == F_PUSH);
   assign push_entry.sample = sample_ff;
   assign push_entry.weight = prod_ff[cad_pkg::WEIGHT_W-1:0];
   assign push_entry.done   = done_ff;
endmodule

/* src/cad_queue.sv */
// Short item queue between the weight front end and the statistics back end.
// Depends on cad_pkg for the entry type.
module cad_queue #(
   parameter int DEPTH = cad_pkg::QUEUE_DEPTH
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push_valid,
   output logic               push_ready,
   input  cad_pkg::entry_type push_entry,
   output logic               pop_valid,
   input  logic               pop,
   output cad_pkg::entry_type pop_entry
);
   localparam int AW = $clog2(DEPTH);
   localparam int NW = $clog2(DEPTH + 1);

   cad_pkg::entry_type mem_ff [DEPTH];
   logic [AW-1:0] wr_ff, rd_ff;
   logic [NW-1:0] cnt_ff;
   logic          do_push, do_pop;

   assign push_ready = (cnt_ff != NW'(DEPTH));
   assign pop_valid  = (cnt_ff != '0);
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && pop_valid;
   assign pop_entry  = mem_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (do_push) wr_ff <= (wr_ff == AW'(DEPTH - 1)) ? '0 : wr_ff + 1'b1;
         if (do_pop)  rd_ff <= (rd_ff == AW'(DEPTH - 1)) ? '0 : rd_ff + 1'b1;
         if (do_push && !do_pop) cnt_ff <= cnt_ff + 1'b1;
         else if (do_pop && !do_push) cnt_ff <= cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) mem_ff[wr_ff] <= push_entry;
   end
endmodule

/* src/cad_back.sv */
// Back end: applies the weight, keeps the saturating sums, holds the result.
// Depends on cad_pkg for the entry type.
module cad_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_valid,
   input  cad_pkg::entry_type  q_entry,
   output logic                q_pop,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic signed [31:0]  rsp_weighted_sample,
   output logic [15:0]         rsp_total_weight,
   output logic signed [63:0]  rsp_running_sum,
   output logic [62:0]         rsp_running_square_sum,
   output logic                rsp_cube_done
);
   typedef enum logic [2:0] {
      B_IDLE   = 3'b001,
      B_PROD   = 3'b010,
      B_SQUARE = 3'b100
   } state_type;

   state_type state_ff;
   logic signed [63:0] prod_ff;
   logic signed [31:0] ws_ff;
   logic [63:0]        sq_ff;
   logic [30:0]        weight_ff;
   logic               done_ff;
   logic signed [63:0] sum_ff;
   logic [62:0]        sqacc_ff;
   logic               valid_ff;

   logic signed [31:0] ws;
   logic [31:0]        mag;
   logic signed [64:0] sum_wide;
   logic signed [63:0] sum_in;
   logic [63:0]        sq_wide;
   logic [62:0]        sqacc_in;
   logic               load;

   assign q_pop = (state_ff == B_IDLE) && q_valid;
   assign ws    = prod_ff[61:30];
   assign mag   = ws[31] ? 32'(-ws) : 32'(ws);
   assign load  = (state_ff == B_SQUARE) && (!valid_ff || rsp_ready);

   always_comb begin
      sum_wide = {sum_ff[63], sum_ff} + 65'(ws_ff);
      if (sum_wide[64] != sum_wide[63])
         sum_in = sum_wide[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
      else
         sum_in = sum_wide[63:0];
      sq_wide  = {1'b0, sqacc_ff} + sq_ff;
      sqacc_in = sq_wide[63] ? {63{1'b1}} : sq_wide[62:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_IDLE;
         valid_ff <= 1'b0;
         sum_ff   <= '0;
         sqacc_ff <= '0;
      end else begin
         unique case (state_ff)
            B_IDLE:   if (q_valid) state_ff <= B_PROD;
            B_PROD:   state_ff <= B_SQUARE;
            B_SQUARE: if (load) state_ff <= B_IDLE;
            default:  state_ff <= B_IDLE;
         endcase
         if (load) begin
            valid_ff <= 1'b1;
            sum_ff   <= done_ff ? '0 : sum_in;
            sqacc_ff <= done_ff ? '0 : sqacc_in;
         end else if (rsp_ready) begin
            valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         prod_ff   <= q_entry.sample * $signed({1'b0, q_entry.weight});
         weight_ff <= q_entry.weight;
         done_ff   <= q_entry.done;
      end
      if (state_ff == B_PROD) begin
         ws_ff <= ws;
         sq_ff <= 64'(mag) * 64'(mag);
      end
      if (load) begin
         rsp_weighted_sample    <= ws_ff;
         rsp_total_weight       <= weight_ff[30:15];
         rsp_running_sum        <= sum_in;
         rsp_running_square_sum <= sqacc_in;
         rsp_cube_done          <= done_ff;
      end
   end

   assign rsp_valid = valid_ff;
endmodule

/* src/cube_apodize_with_stats_core.sv */
// Cube apodization core: config registers, weight front end, queue, stats back end.
// The time from accept to result valid depends on the divider, used
// up to four times per item (taper, two axes, radial ramp), and on the 32-step square root.
// The front end takes a new item only after its pass for the last one ends; back end overlaps.
// Reset (synchronous): counters, sums and handshakes clear; registers take defaults.
module cube_apodize_with_stats_core #(
   parameter int MAX_COLUMNS = cad_pkg::MAX_COLUMNS_DEF,
   parameter int MAX_ROWS    = cad_pkg::MAX_ROWS_DEF,
   parameter int MAX_PLANES  = cad_pkg::MAX_PLANES_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [cad_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [cad_pkg::CSR_DATA_W-1:0]      csr_data,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic signed [31:0]                  req_sample,
   input  logic                                req_sample_invalid,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [31:0]                  rsp_weighted_sample,
   output logic [15:0]                         rsp_total_weight,
   output logic signed [63:0]                  rsp_running_sum,
   output logic [62:0]                         rsp_running_square_sum,
   output logic                                rsp_cube_done
);
   cad_pkg::cfg_type   cfg_ff;
   logic               push_valid, push_ready, pop_valid, pop;
   cad_pkg::entry_type push_entry, pop_entry;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.columns    <= cad_pkg::COLS_RST;
         cfg_ff.rows       <= cad_pkg::ROWS_RST;
         cfg_ff.planes     <= cad_pkg::PLANES_RST;
         cfg_ff.inner_edge <= cad_pkg::INNER_RST;
         cfg_ff.outer_edge <= cad_pkg::OUTER_RST;
         cfg_ff.time_edge  <= cad_pkg::TIME_RST;
      end else if (csr_valid) begin
         unique case (cad_pkg::csr_index_type'(csr_index))
            cad_pkg::CSR_COLUMNS:   cfg_ff.columns    <= csr_data[cad_pkg::COLS_W-1:0];
            cad_pkg::CSR_ROWS:      cfg_ff.rows       <= csr_data[cad_pkg::ROWS_W-1:0];
            cad_pkg::CSR_PLANES:    cfg_ff.planes     <= csr_data[cad_pkg::PLANES_W-1:0];
            cad_pkg::CSR_INNER:     cfg_ff.inner_edge <= csr_data;
            cad_pkg::CSR_OUTER:     cfg_ff.outer_edge <= csr_data;
            cad_pkg::CSR_TIME_EDGE: cfg_ff.time_edge  <= csr_data;
            default: begin
            end
         endcase
      end
   end

   cad_front #(
      .MAX_COLUMNS (MAX_COLUMNS),
      .MAX_ROWS    (MAX_ROWS),
      .MAX_PLANES  (MAX_PLANES)
   ) u_front (
      .clock              (clock),
      .reset              (reset),
      .cfg                (cfg_ff),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_sample         (req_sample),
      .req_sample_invalid (req_sample_invalid),
      .push_valid         (push_valid),
      .push_ready         (push_ready),
      .push_entry         (push_entry)
   );

   cad_queue #(
      .DEPTH (cad_pkg::QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry),
      .pop_valid  (pop_valid),
      .pop        (pop),
      .pop_entry  (pop_entry)
   );

   cad_back u_back (
      .clock                  (clock),
      .reset                  (reset),
      .q_valid                (pop_valid),
      .q_entry                (pop_entry),
      .q_pop                  (pop),
      .rsp_valid              (rsp_valid),
      .rsp_ready              (rsp_ready),
      .rsp_weighted_sample    (rsp_weighted_sample),
      .rsp_total_weight       (rsp_total_weight),
      .rsp_running_sum        (rsp_running_sum),
      .rsp_running_square_sum (rsp_running_square_sum),
      .rsp_cube_done          (rsp_cube_done)
   );
endmodule
